[hdl/rcd_pkg.sv]
package rcd_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int CMD_WIDTH          = 4;
   localparam int STATUS_WIDTH       = 3;
   localparam int UPC_WIDTH          = 4;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_ADD_END   = 4'd0,
      CMD_ADD_FRONT = 4'd1,
      CMD_DEL_END   = 4'd2,
      CMD_DEL_FRONT = 4'd3,
      CMD_READ      = 4'd4,
      CMD_WRITE     = 4'd5,
      CMD_CLEAR     = 4'd6,
      CMD_REVERSE   = 4'd7,
      CMD_SEARCH    = 4'd8
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_RANGE     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   // Guard tested by a step before it acts.
   typedef enum logic [2:0] {
      CHK_NONE,
      CHK_FULL,
      CHK_EMPTY,
      CHK_RANGE,
      CHK_WALK,
      CHK_MATCH
   } chk_type;

   // Logical index fed to the slot address unit.
   typedef enum logic [2:0] {
      IDX_ONE,
      IDX_COUNT,
      IDX_COUNT_M1,
      IDX_POS,
      IDX_WALK
   } idx_type;

   typedef enum logic [1:0] {
      FRONT_HOLD,
      FRONT_SLOT,
      FRONT_SLOT_NZ,
      FRONT_ZERO
   } front_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLEAR
   } cnt_op_type;

   typedef enum logic [1:0] {
      REV_HOLD,
      REV_TOGGLE,
      REV_CLEAR
   } rev_op_type;

   typedef struct packed {
      chk_type                chk;
      idx_type                isel;
      logic                   dinv;
      logic                   mem_wr;
      logic                   mem_rd;
      front_op_type           front_op;
      cnt_op_type             cnt_op;
      rev_op_type             rev_op;
      logic                   walk_inc;
      logic                   out_data;
      logic                   last;
      logic                   jump;
      logic [UPC_WIDTH-1:0]   target;
   } ctrl_word_type;

   // Microcode addresses. Two-step programs sit at consecutive addresses.
   localparam logic [UPC_WIDTH-1:0] UA_ADD_END    = 4'd0;
   localparam logic [UPC_WIDTH-1:0] UA_ADD_FRONT  = 4'd1;
   localparam logic [UPC_WIDTH-1:0] UA_DEL_END    = 4'd2;
   localparam logic [UPC_WIDTH-1:0] UA_DEL_FRONT  = 4'd3;
   localparam logic [UPC_WIDTH-1:0] UA_READ_RD    = 4'd4;
   localparam logic [UPC_WIDTH-1:0] UA_READ_OUT   = 4'd5;
   localparam logic [UPC_WIDTH-1:0] UA_WRITE      = 4'd6;
   localparam logic [UPC_WIDTH-1:0] UA_CLEAR      = 4'd7;
   localparam logic [UPC_WIDTH-1:0] UA_REVERSE    = 4'd8;
   localparam logic [UPC_WIDTH-1:0] UA_SEARCH_RD  = 4'd9;
   localparam logic [UPC_WIDTH-1:0] UA_SEARCH_CMP = 4'd10;
   localparam logic [UPC_WIDTH-1:0] UA_NOP        = 4'd11;

   localparam ctrl_word_type CTRL_IDLE = '{
      chk:      CHK_NONE,
      isel:     IDX_ONE,
      dinv:     1'b0,
      mem_wr:   1'b0,
      mem_rd:   1'b0,
      front_op: FRONT_HOLD,
      cnt_op:   CNT_HOLD,
      rev_op:   REV_HOLD,
      walk_inc: 1'b0,
      out_data: 1'b0,
      last:     1'b0,
      jump:     1'b0,
      target:   UA_NOP
   };

   function automatic logic [UPC_WIDTH-1:0] ucode_entry(input cmd_type cmd);
      logic [UPC_WIDTH-1:0] addr;
      unique case (cmd)
         CMD_ADD_END:   addr = UA_ADD_END;
         CMD_ADD_FRONT: addr = UA_ADD_FRONT;
         CMD_DEL_END:   addr = UA_DEL_END;
         CMD_DEL_FRONT: addr = UA_DEL_FRONT;
         CMD_READ:      addr = UA_READ_RD;
         CMD_WRITE:     addr = UA_WRITE;
         CMD_CLEAR:     addr = UA_CLEAR;
         CMD_REVERSE:   addr = UA_REVERSE;
         CMD_SEARCH:    addr = UA_SEARCH_RD;
         default:       addr = UA_NOP;
      endcase
      return addr;
   endfunction

   function automatic ctrl_word_type ucode_rom(input logic [UPC_WIDTH-1:0] addr);
      ctrl_word_type w;
      w = CTRL_IDLE;
      unique case (addr)
         UA_ADD_END: begin
            w.chk    = CHK_FULL;
            w.isel   = IDX_COUNT;
            w.mem_wr = 1'b1;
            w.cnt_op = CNT_INC;
            w.last   = 1'b1;
         end
         UA_ADD_FRONT: begin
            // The slot one step behind the front is both the new front and
            // the place the new element lands.
            w.chk      = CHK_FULL;
            w.isel     = IDX_ONE;
            w.dinv     = 1'b1;
            w.mem_wr   = 1'b1;
            w.front_op = FRONT_SLOT;
            w.cnt_op   = CNT_INC;
            w.last     = 1'b1;
         end
         UA_DEL_END: begin
            w.chk    = CHK_EMPTY;
            w.cnt_op = CNT_DEC;
            w.last   = 1'b1;
         end
         UA_DEL_FRONT: begin
            w.chk      = CHK_EMPTY;
            w.isel     = IDX_ONE;
            w.front_op = FRONT_SLOT;
            w.cnt_op   = CNT_DEC;
            w.last     = 1'b1;
         end
         UA_READ_RD: begin
            w.chk    = CHK_RANGE;
            w.isel   = IDX_POS;
            w.mem_rd = 1'b1;
         end
         UA_READ_OUT: begin
            w.out_data = 1'b1;
            w.last     = 1'b1;
         end
         UA_WRITE: begin
            w.chk    = CHK_RANGE;
            w.isel   = IDX_POS;
            w.mem_wr = 1'b1;
            w.last   = 1'b1;
         end
         UA_CLEAR: begin
            w.front_op = FRONT_ZERO;
            w.cnt_op   = CNT_CLEAR;
            w.rev_op   = REV_CLEAR;
            w.last     = 1'b1;
         end
         UA_REVERSE: begin
            w.isel     = IDX_COUNT_M1;
            w.front_op = FRONT_SLOT_NZ;
            w.rev_op   = REV_TOGGLE;
            w.last     = 1'b1;
         end
         UA_SEARCH_RD: begin
            w.chk    = CHK_WALK;
            w.isel   = IDX_WALK;
            w.mem_rd = 1'b1;
         end
         UA_SEARCH_CMP: begin
            w.chk      = CHK_MATCH;
            w.walk_inc = 1'b1;
            w.jump     = 1'b1;
            w.target   = UA_SEARCH_RD;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

[hdl/rcd_sequencer.sv]
module rcd_sequencer
   import rcd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [CMD_WIDTH-1:0] cmd,
   input  logic                 stop,
   output ctrl_word_type        ctrl,
   output logic                 running
);

   logic [UPC_WIDTH-1:0] upc_ff, upc_in;
   logic                 running_ff, running_in;

   always_comb begin
      ctrl = ucode_rom(upc_ff);
   end

   // A step ends the program when its word is marked last or when its guard
   // stops it; otherwise the counter steps on or jumps.
   always_comb begin
      upc_in     = upc_ff;
      running_in = running_ff;
      if (go) begin
         running_in = 1'b1;
         upc_in     = ucode_entry(cmd_type'(cmd));
      end else if (running_ff) begin
         if (ctrl.last || stop) begin
            running_in = 1'b0;
         end else if (ctrl.jump) begin
            upc_in = ctrl.target;
         end else begin
            upc_in = upc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff     <= UA_NOP;
         running_ff <= 1'b0;
      end else begin
         upc_ff     <= upc_in;
         running_ff <= running_in;
      end
   end

   assign running = running_ff;

endmodule

[hdl/reversible_circular_deque.sv]
// Reversible circular deque. A command beat is taken at a rising edge where
// start is high and busy is low; its single result beat appears on the rsp_
// ports for exactly one cycle, marked by rsp_valid, and must be taken then,
// since there is no way to hold it off. Busy is already low in the cycle that
// shows a result, so the next command can be taken at the edge that ends it.
// Each command runs a short microcode program, one step per cycle, followed
// by one cycle in which the result is shown. Add, delete, write, clear,
// reverse and unused codes are one step. Read is two steps (address, then
// the registered memory read). Search spends two steps on each element it
// inspects because every compare waits on the registered read of the single
// memory port. Every result reports the length left after the command.
// Stored data does not reset; only the front pointer, count, order flag and
// result valid flag do.
module reversible_circular_deque
   import rcd_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [CMD_WIDTH-1:0]           req_command,
   input  logic [$clog2(DEPTH)-1:0]       req_position,
   input  logic [DATA_WIDTH-1:0]          req_data_in,
   output logic                           rsp_valid,
   output logic [DATA_WIDTH-1:0]          rsp_data_out,
   output logic [$clog2(DEPTH)-1:0]       rsp_found_position,
   output logic [STATUS_WIDTH-1:0]        rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]     rsp_length
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [CW-1:0] DEPTH_CNT  = CW'(DEPTH);
   localparam logic [AW:0]   DEPTH_WIDE = (AW + 1)'(DEPTH);

   // Element storage: one write or one read per cycle, read data registered.
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   // Queue state.
   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rev_ff, rev_in;

   // Captured command operands and the search cursor.
   logic [AW-1:0]         pos_ff;
   logic [DATA_WIDTH-1:0] data_ff;
   logic [CW-1:0]         walk_ff, walk_in;

   // Result registers.
   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] rsp_data_out_ff;
   logic [AW-1:0]         rsp_found_ff;
   status_type            rsp_status_ff;
   logic [CW-1:0]         rsp_length_ff;

   ctrl_word_type ctrl;
   logic          running;
   logic          go;
   logic          fail;
   logic          hit;
   logic          stop;
   logic          act;
   logic          finish;
   status_type    status_code;
   logic [AW-1:0] idx;
   logic [CW-1:0] count_m1;
   logic          dir_rev;
   logic [AW:0]   fwd_sum;
   logic [AW:0]   rev_wrap;
   logic [AW-1:0] slot;

   assign go   = start && !busy;
   assign busy = running;

   rcd_sequencer u_sequencer (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .cmd     (req_command),
      .stop    (stop),
      .ctrl    (ctrl),
      .running (running)
   );

   // Step guards. A failed guard ends the program with its status and the
   // step does nothing else. A search compare that hits also ends it.
   always_comb begin
      fail        = 1'b0;
      hit         = 1'b0;
      status_code = ST_OK;
      case (ctrl.chk)
         CHK_FULL: begin
            if (count_ff == DEPTH_CNT) begin
               fail        = 1'b1;
               status_code = ST_FULL;
            end
         end
         CHK_EMPTY: begin
            if (count_ff == '0) begin
               fail        = 1'b1;
               status_code = ST_EMPTY;
            end
         end
         CHK_RANGE: begin
            if (CW'(pos_ff) >= count_ff) begin
               fail        = 1'b1;
               status_code = ST_RANGE;
            end
         end
         CHK_WALK: begin
            if (walk_ff >= count_ff) begin
               fail        = 1'b1;
               status_code = ST_NOT_FOUND;
            end
         end
         CHK_MATCH: begin
            hit = (rdata_ff == data_ff);
         end
         default: begin
         end
      endcase
   end

   assign stop   = running && (fail || hit);
   assign act    = running && !stop;
   assign finish = running && (ctrl.last || stop);

   // Logical index for the address unit. Each index is below DEPTH whenever
   // a step gets past its guard and uses the slot, so the low bits suffice.
   assign count_m1 = count_ff - CW'(1);

   always_comb begin
      case (ctrl.isel)
         IDX_ONE:      idx = AW'(1);
         IDX_COUNT:    idx = count_ff[AW-1:0];
         IDX_COUNT_M1: idx = count_m1[AW-1:0];
         IDX_POS:      idx = pos_ff;
         IDX_WALK:     idx = walk_ff[AW-1:0];
         default:      idx = '0;
      endcase
   end

   // Physical slot: front plus index in forward order, front minus index in
   // reversed order, wrapped at DEPTH with a single compare and correction.
   // The inverted direction is what moves the front back for an add at the
   // front.
   assign dir_rev  = rev_ff ^ ctrl.dinv;
   assign fwd_sum  = {1'b0, front_ff} + {1'b0, idx};
   assign rev_wrap = {1'b0, front_ff} + DEPTH_WIDE - {1'b0, idx};

   always_comb begin
      if (dir_rev) begin
         if (front_ff >= idx) begin
            slot = front_ff - idx;
         end else begin
            slot = rev_wrap[AW-1:0];
         end
      end else begin
         if (fwd_sum >= DEPTH_WIDE) begin
            slot = AW'(fwd_sum - DEPTH_WIDE);
         end else begin
            slot = fwd_sum[AW-1:0];
         end
      end
   end

   // Next state of the queue.
   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      rev_in   = rev_ff;
      walk_in  = walk_ff;
      if (go) begin
         walk_in = '0;
      end
      if (act) begin
         case (ctrl.front_op)
            FRONT_SLOT:    front_in = slot;
            FRONT_SLOT_NZ: front_in = (count_ff != '0) ? slot : front_ff;
            FRONT_ZERO:    front_in = '0;
            default:       front_in = front_ff;
         endcase
         case (ctrl.cnt_op)
            CNT_INC:   count_in = count_ff + CW'(1);
            CNT_DEC:   count_in = count_m1;
            CNT_CLEAR: count_in = '0;
            default:   count_in = count_ff;
         endcase
         case (ctrl.rev_op)
            REV_TOGGLE: rev_in = !rev_ff;
            REV_CLEAR:  rev_in = 1'b0;
            default:    rev_in = rev_ff;
         endcase
         if (ctrl.walk_inc) begin
            walk_in = walk_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         rsp_valid_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
      if (go) begin
         pos_ff  <= req_position;
         data_ff <= req_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (act && ctrl.mem_wr) begin
         mem[slot] <= data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (act && ctrl.mem_rd) begin
         rdata_ff <= mem[slot];
      end
   end

   // The result beat carries the length as it stands after this command.
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_out_ff <= (act && ctrl.out_data) ? rdata_ff : '0;
         rsp_found_ff    <= hit ? walk_ff[AW-1:0] : '0;
         rsp_status_ff   <= status_code;
         rsp_length_ff   <= count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_out       = rsp_data_out_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_length         = rsp_length_ff;

endmodule

[hdl/rcd_checker.sv]
module rcd_checker
   import rcd_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [STATUS_WIDTH-1:0]    rsp_status,
   input logic [$clog2(DEPTH+1)-1:0] rsp_length
);

   localparam int CW = $clog2(DEPTH + 1);

   // Checks that an accepted command raises busy; the block then stays busy until its result.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command beat taken but busy not raised");

   // A result beat lasts one cycle and the block is free while it shows.
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat held for more than one cycle");

   a_free_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while a result beat is shown");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> rsp_length == CW'(DEPTH))
      else $error("full status with a length below capacity");

   a_empty_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> rsp_length == '0)
      else $error("empty status with a nonzero length");

endmodule

bind reversible_circular_deque rcd_checker #(.DEPTH(DEPTH)) u_rcd_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status),
   .rsp_length (rsp_length)
);
